// ===== sv/arvs_pkg.sv =====
// shared types, constants and helpers for the atmosphere rim vertex shade unit
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package arvs_pkg;

  localparam int unsigned SQRT_K    = 31;
  localparam int unsigned DIV_QW    = 31;
  localparam int unsigned DIV_NW    = 31;
  localparam int unsigned DIV_LANES = 6;
  localparam int unsigned DIV_HALF  = 3;

  localparam logic [2:0] REG_EYE_X = 3'd0;
  localparam logic [2:0] REG_EYE_Y = 3'd1;
  localparam logic [2:0] REG_EYE_Z = 3'd2;
  localparam logic [2:0] REG_SUN_X = 3'd3;
  localparam logic [2:0] REG_SUN_Y = 3'd4;
  localparam logic [2:0] REG_SUN_Z = 3'd5;
  localparam logic [2:0] REG_FADE  = 3'd6;

  localparam logic signed [15:0] SUN_X_RST = 16'sd16384;
  localparam logic [16:0] Q_ONE = 17'd65536;

  localparam logic [21:0] RECIP_7  = 22'((1 << 24) / 7);
  localparam logic [21:0] RECIP_9  = 22'((1 << 24) / 9);
  localparam logic [21:0] RECIP_10 = 22'((1 << 24) / 10);
  localparam logic [21:0] RECIP_20 = 22'((1 << 24) / 20);

  localparam logic [2:0][15:0] SKY  = {16'd65535, 16'd36700, 16'd22282};
  localparam logic [2:0][15:0] WARM = {16'd24903, 16'd40632, 16'd65535};

  typedef struct packed {
    logic            zero;
    logic [2:0]      dneg;
    logic [2:0]      vneg;
    logic [2:0][29:0] dm;
    logic [2:0][23:0] vm;
  } front_side_t;

  localparam int unsigned FRONT_SIDE_W = $bits(front_side_t);

  typedef struct packed {
    logic       zero;
    logic       vzero;
    logic [2:0] dneg;
    logic [2:0] vneg;
  } div_side_t;

  localparam int unsigned DIV_SIDE_W = $bits(div_side_t);

  typedef struct packed {
    logic        wr;
    logic [15:0] alpha;
    logic [15:0] blue;
    logic [15:0] green;
    logic [15:0] red;
  } pix_t;

  // quotient estimate by reciprocal, low by at most one for x below 2^24
  function automatic logic [23:0] qest(input logic [23:0] x, input logic [21:0] m);
    logic [45:0] p;
    p = x * m;
    return 24'(p[45:24]);
  endfunction

  function automatic logic [23:0] qfix(input logic [23:0] x, input logic [23:0] qe,
                                       input logic [4:0] dv);
    logic [28:0] p;
    logic [23:0] r;
    p = qe * dv;
    r = x - p[23:0];
    return (r >= 24'(dv)) ? qe + 24'd1 : qe;
  endfunction

endpackage

`default_nettype wire

// ===== sv/arvs_isqrt.sv =====
// two-lane pipelined integer square root, one result bit per stage
// depends on arvs_pkg
`timescale 1ns / 1ps
`default_nettype none

module arvs_isqrt import arvs_pkg::*; #(
  parameter int unsigned K      = SQRT_K,
  parameter int unsigned SIDE_W = FRONT_SIDE_W
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              vld_i,
  input  logic [2*K-1:0]    xa_i,
  input  logic [2*K-1:0]    xb_i,
  input  logic [SIDE_W-1:0] side_i,
  output logic              vld_o,
  output logic [K-1:0]      ra_o,
  output logic [K-1:0]      rb_o,
  output logic [SIDE_W-1:0] side_o
);

  localparam int unsigned W = 2 * K;

  logic [K-1:0]      vld_q;
  logic [W-1:0]      xa_q [K];
  logic [W-1:0]      ra_q [K];
  logic [W-1:0]      xb_q [K];
  logic [W-1:0]      rb_q [K];
  logic [SIDE_W-1:0] side_q [K];

  logic [W-1:0] xa_in [K];
  logic [W-1:0] ra_in [K];
  logic [W-1:0] xb_in [K];
  logic [W-1:0] rb_in [K];
  logic [W-1:0] xa_nx [K];
  logic [W-1:0] ra_nx [K];
  logic [W-1:0] xb_nx [K];
  logic [W-1:0] rb_nx [K];
  logic [W-1:0] bitv  [K];
  logic [W-1:0] suma  [K];
  logic [W-1:0] sumb  [K];

  always_comb begin
    xa_in[0] = xa_i;
    xb_in[0] = xb_i;
    ra_in[0] = '0;
    rb_in[0] = '0;
    for (int s = 1; s < K; s++) begin
      xa_in[s] = xa_q[s-1];
      xb_in[s] = xb_q[s-1];
      ra_in[s] = ra_q[s-1];
      rb_in[s] = rb_q[s-1];
    end
    for (int s = 0; s < K; s++) begin
      bitv[s] = W'(1) << (2 * (K - 1 - s));
      suma[s] = ra_in[s] + bitv[s];
      sumb[s] = rb_in[s] + bitv[s];
      if (xa_in[s] >= suma[s]) begin
        xa_nx[s] = xa_in[s] - suma[s];
        ra_nx[s] = (ra_in[s] >> 1) + bitv[s];
      end else begin
        xa_nx[s] = xa_in[s];
        ra_nx[s] = ra_in[s] >> 1;
      end
      if (xb_in[s] >= sumb[s]) begin
        xb_nx[s] = xb_in[s] - sumb[s];
        rb_nx[s] = (rb_in[s] >> 1) + bitv[s];
      end else begin
        xb_nx[s] = xb_in[s];
        rb_nx[s] = rb_in[s] >> 1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[K-2:0], vld_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      side_q[0] <= side_i;
      for (int s = 1; s < K; s++) begin
        side_q[s] <= side_q[s-1];
      end
      for (int s = 0; s < K; s++) begin
        xa_q[s] <= xa_nx[s];
        ra_q[s] <= ra_nx[s];
        xb_q[s] <= xb_nx[s];
        rb_q[s] <= rb_nx[s];
      end
    end
  end

  assign vld_o  = vld_q[K-1];
  assign ra_o   = ra_q[K-1][K-1:0];
  assign rb_o   = rb_q[K-1][K-1:0];
  assign side_o = side_q[K-1];

endmodule

`default_nettype wire

// ===== sv/arvs_div.sv =====
// six-lane pipelined restoring divider, one quotient bit per stage
// lanes 0..2 share divisor a, lanes 3..5 share divisor b; depends on arvs_pkg
`timescale 1ns / 1ps
`default_nettype none

module arvs_div import arvs_pkg::*; #(
  parameter int unsigned QW     = DIV_QW,
  parameter int unsigned NW     = DIV_NW,
  parameter int unsigned SIDE_W = DIV_SIDE_W
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          en_i,
  input  logic                          vld_i,
  input  logic [DIV_LANES-1:0][NW-1:0]  num_i,
  input  logic [NW-1:0]                 den_a_i,
  input  logic [NW-1:0]                 den_b_i,
  input  logic [SIDE_W-1:0]             side_i,
  output logic                          vld_o,
  output logic [DIV_LANES-1:0][QW-1:0]  quo_o,
  output logic [SIDE_W-1:0]             side_o
);

  logic [QW-1:0]                  vld_q;
  logic [DIV_LANES-1:0][NW-1:0]   rem_q  [QW];
  logic [DIV_LANES-1:0][QW-1:0]   quo_q  [QW];
  logic [NW-1:0]                  da_q   [QW];
  logic [NW-1:0]                  db_q   [QW];
  logic [SIDE_W-1:0]              side_q [QW];

  logic [DIV_LANES-1:0][NW:0]     ri     [QW];
  logic [DIV_LANES-1:0][QW-1:0]   qi     [QW];
  logic [NW-1:0]                  da_in  [QW];
  logic [NW-1:0]                  db_in  [QW];
  logic [DIV_LANES-1:0][NW-1:0]   rem_nx [QW];
  logic [DIV_LANES-1:0][QW-1:0]   quo_nx [QW];
  logic [NW:0]                    den    [QW][DIV_LANES];
  logic [DIV_LANES-1:0]           ge     [QW];

  always_comb begin
    da_in[0] = den_a_i;
    db_in[0] = den_b_i;
    qi[0]    = '0;
    for (int l = 0; l < DIV_LANES; l++) begin
      ri[0][l] = {1'b0, num_i[l]};
    end
    for (int s = 1; s < QW; s++) begin
      da_in[s] = da_q[s-1];
      db_in[s] = db_q[s-1];
      qi[s]    = quo_q[s-1];
      for (int l = 0; l < DIV_LANES; l++) begin
        ri[s][l] = {rem_q[s-1][l], 1'b0};
      end
    end
    for (int s = 0; s < QW; s++) begin
      for (int l = 0; l < DIV_LANES; l++) begin
        den[s][l] = (l < DIV_HALF) ? {1'b0, da_in[s]} : {1'b0, db_in[s]};
        ge[s][l]  = ri[s][l] >= den[s][l];
        rem_nx[s][l] = ge[s][l] ? NW'(ri[s][l] - den[s][l]) : NW'(ri[s][l]);
        quo_nx[s][l] = {qi[s][l][QW-2:0], ge[s][l]};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[QW-2:0], vld_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      side_q[0] <= side_i;
      for (int s = 1; s < QW; s++) begin
        side_q[s] <= side_q[s-1];
      end
      for (int s = 0; s < QW; s++) begin
        rem_q[s] <= rem_nx[s];
        quo_q[s] <= quo_nx[s];
        da_q[s]  <= da_in[s];
        db_q[s]  <= db_in[s];
      end
    end
  end

  assign vld_o  = vld_q[QW-1];
  assign quo_o  = quo_q[QW-1];
  assign side_o = side_q[QW-1];

endmodule

`default_nettype wire

// ===== sv/arvs_shade.sv =====
// shading back end: dot products, grazing cube, terminator, tint mix and alpha
// eleven register stages; depends on arvs_pkg
`timescale 1ns / 1ps
`default_nettype none

module arvs_shade import arvs_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic               vld_i,
  input  logic               zero_i,
  input  logic signed [31:0] u_i [3],
  input  logic signed [31:0] n_i [3],
  input  logic signed [15:0] sun_x_i,
  input  logic signed [15:0] sun_y_i,
  input  logic signed [15:0] sun_z_i,
  input  logic [15:0]        fade_i,
  output logic               vld_o,
  output pix_t               pix_o
);

  logic [10:0] vld_q;
  logic [10:0] zero_q;

  logic signed [15:0] sun [3];
  logic signed [62:0] pu_q [3];
  logic signed [47:0] sn_q [3];
  logic signed [62:0] dot_q;
  logic signed [47:0] sdot_q;
  logic [61:0] dmag;
  logic [46:0] sdmag;
  logic [17:0] c18;
  logic [16:0] g3_q, g4_q;
  logic [18:0] sdm_q;
  logic        sdneg_q;
  logic [19:0] num;
  logic [23:0] xl_d, xd_d;
  logic [23:0] xl_q, xd_q, qle_q, qde_q;
  logic [33:0] g2_q;
  logic [23:0] ql, qd;
  logic [16:0] lit5_q, w5_q;
  logic [50:0] g3p_q;
  logic [33:0] tl_q;
  logic [23:0] tx_d, tx_q, qte_q;
  logic [16:0] a1_q, t7_q;
  logic [23:0] qt;
  logic [32:0] fa;
  logic [17:0] a2_q;
  logic [33:0] chs [3];
  logic [2:0][15:0] ch8_q, ch9_q, ch10_q;
  logic [23:0] ax_d, ax_q, qae_q, qa;
  logic [16:0] a10_q;
  logic [32:0] ap;
  logic [16:0] tlo;
  pix_t        pix_q;

  always_comb begin
    sun[0] = sun_x_i;
    sun[1] = sun_y_i;
    sun[2] = sun_z_i;
    dmag  = dot_q[62] ? 62'(-dot_q) : 62'(dot_q);
    sdmag = sdot_q[47] ? 47'(-sdot_q) : 47'(sdot_q);
    c18   = dmag[61:44];
    num   = '0;
    xl_d  = '0;
    if (sdneg_q) begin
      if (sdm_q < 19'd16384) begin
        num  = 20'd16384 - 20'(sdm_q);
        xl_d = 24'(num) * 24'd20;
      end
    end else begin
      num  = 20'(sdm_q) + 20'd16384;
      xl_d = 24'(num) * 24'd20;
    end
    xd_d = 24'(sdm_q) * 24'd20;
    ql   = qfix(xl_q, qle_q, 5'd9);
    qd   = qfix(xd_q, qde_q, 5'd7);
    tx_d = 24'(w5_q) * 24'd7;
    qt   = qfix(tx_q, qte_q, 5'd10);
    fa   = a1_q * fade_i;
    tlo  = Q_ONE - t7_q;
    for (int i = 0; i < 3; i++) begin
      chs[i] = 34'(SKY[i]) * 34'(tlo) + 34'(WARM[i]) * 34'(t7_q) + 34'd32768;
    end
    ax_d = 24'(a2_q) * 24'd19;
    qa   = qfix(ax_q, qae_q, 5'd20);
    ap   = 33'(a10_q) * 33'd65535 + 33'd32768;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[9:0], vld_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      zero_q <= {zero_q[9:0], zero_i};
      // products of unit vectors
      for (int i = 0; i < 3; i++) begin
        pu_q[i] <= 63'(u_i[i]) * 63'(n_i[i]);
        sn_q[i] <= 48'(n_i[i]) * 48'(sun[i]);
      end
      dot_q  <= pu_q[0] + pu_q[1] + pu_q[2];
      sdot_q <= sn_q[0] + sn_q[1] + sn_q[2];
      // grazing factor and sun dot in q16
      g3_q    <= (c18 > 18'(Q_ONE)) ? 17'd0 : Q_ONE - c18[16:0];
      sdm_q   <= sdmag[46:28];
      sdneg_q <= sdot_q[47];
      g4_q  <= g3_q;
      g2_q  <= g3_q * g3_q;
      xl_q  <= xl_d;
      xd_q  <= xd_d;
      qle_q <= qest(xl_d, RECIP_9);
      qde_q <= qest(xd_d, RECIP_7);
      lit5_q <= (ql > 24'(Q_ONE)) ? Q_ONE : ql[16:0];
      w5_q   <= (qd >= 24'(Q_ONE)) ? 17'd0 : 17'(24'(Q_ONE) - qd);
      g3p_q  <= g2_q * g4_q;
      tl_q  <= g3p_q[48:32] * lit5_q;
      tx_q  <= tx_d;
      qte_q <= qest(tx_d, RECIP_10);
      a1_q <= tl_q[32:16];
      t7_q <= qt[16:0];
      a2_q <= fa[32:15];
      for (int i = 0; i < 3; i++) begin
        ch8_q[i] <= chs[i][31:16];
      end
      ax_q  <= ax_d;
      qae_q <= qest(ax_d, RECIP_20);
      ch9_q <= ch8_q;
      a10_q  <= (qa > 24'(Q_ONE)) ? Q_ONE : qa[16:0];
      ch10_q <= ch9_q;
      if (zero_q[9]) begin
        pix_q <= '0;
      end else begin
        pix_q.wr    <= 1'b1;
        pix_q.alpha <= ap[31:16];
        pix_q.red   <= ch10_q[0];
        pix_q.green <= ch10_q[1];
        pix_q.blue  <= ch10_q[2];
      end
    end
  end

  assign vld_o = vld_q[10];
  assign pix_o = pix_q;

endmodule

`default_nettype wire

// ===== sv/atmosphere_rim_vertex_shade_unit.sv =====
// throughput: one vertex per cycle except while the skid entry holds a result; the two square
// roots and six divisions are pipelined one bit per stage, which sets the depth
// a two-entry output buffer lets the input side run while a result waits
// reset: asynchronous active low; clears valid bits and loads register defaults
`timescale 1ns / 1ps
`default_nettype none

module atmosphere_rim_vertex_shade_unit import arvs_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [31:0] cfg_data_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [71:0] s_axis_tdata,   // vertex_x, vertex_y, vertex_z
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata,   // red, green, blue, alpha
  output logic        m_axis_tuser    // write_colour
);

  logic signed [31:0] eye_q [3];
  logic signed [15:0] sun_q [3];
  logic [15:0]        fade_q;

  logic en;

  logic               f1_vld_q, f2_vld_q, f3_vld_q, f4_vld_q;
  logic signed [23:0] vin   [3];
  logic signed [23:0] v1_q  [3];
  logic signed [32:0] d1_q  [3];
  logic [32:0]        dmag  [3];
  logic [32:0]        mx;
  logic [1:0]         sh;
  front_side_t        f2_d, f2_q, f3_q, f4_q;
  logic [59:0]        dsq_q [3];
  logic [47:0]        vsq_q [3];
  logic [61:0]        sqd_q, sqv_q;

  logic                        sq_vld;
  logic [SQRT_K-1:0]           nd, nv;
  logic [FRONT_SIDE_W-1:0]     sq_side;
  front_side_t                 sq_fs;
  logic [DIV_LANES-1:0][DIV_NW-1:0] num;
  div_side_t                   dv_in, dv_out;
  logic [DIV_SIDE_W-1:0]       dv_side;
  logic                        dv_vld;
  logic [DIV_LANES-1:0][DIV_QW-1:0] quo;
  logic signed [31:0]          u [3];
  logic signed [31:0]          n [3];

  logic pipe_vld;
  pix_t pipe_pix;
  logic out_vld_q, skid_vld_q;
  pix_t out_q, skid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      eye_q[0] <= '0;
      eye_q[1] <= '0;
      eye_q[2] <= '0;
      sun_q[0] <= SUN_X_RST;
      sun_q[1] <= '0;
      sun_q[2] <= '0;
      fade_q   <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_EYE_X: eye_q[0] <= cfg_data_i;
        REG_EYE_Y: eye_q[1] <= cfg_data_i;
        REG_EYE_Z: eye_q[2] <= cfg_data_i;
        REG_SUN_X: sun_q[0] <= cfg_data_i[15:0];
        REG_SUN_Y: sun_q[1] <= cfg_data_i[15:0];
        REG_SUN_Z: sun_q[2] <= cfg_data_i[15:0];
        REG_FADE:  fade_q   <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  assign en            = !skid_vld_q;
  assign s_axis_tready = en;

  // front end: offset, range scaling, squares, sums
  always_comb begin
    vin[0] = s_axis_tdata[23:0];
    vin[1] = s_axis_tdata[47:24];
    vin[2] = s_axis_tdata[71:48];
    mx = '0;
    for (int i = 0; i < 3; i++) begin
      dmag[i] = d1_q[i][32] ? 33'(-d1_q[i]) : 33'(d1_q[i]);
      if (dmag[i] > mx) begin
        mx = dmag[i];
      end
    end
    if (mx[32]) begin
      sh = 2'd3;
    end else if (mx[31]) begin
      sh = 2'd2;
    end else if (mx[30]) begin
      sh = 2'd1;
    end else begin
      sh = 2'd0;
    end
    f2_d.zero = (d1_q[0] == '0) && (d1_q[1] == '0) && (d1_q[2] == '0);
    for (int i = 0; i < 3; i++) begin
      f2_d.dneg[i] = d1_q[i][32];
      f2_d.vneg[i] = v1_q[i][23];
      f2_d.dm[i]   = 30'(dmag[i] >> sh);
      f2_d.vm[i]   = v1_q[i][23] ? 24'(-v1_q[i]) : 24'(v1_q[i]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f1_vld_q <= 1'b0;
      f2_vld_q <= 1'b0;
      f3_vld_q <= 1'b0;
      f4_vld_q <= 1'b0;
    end else if (en) begin
      f1_vld_q <= s_axis_tvalid;
      f2_vld_q <= f1_vld_q;
      f3_vld_q <= f2_vld_q;
      f4_vld_q <= f3_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        v1_q[i]  <= vin[i];
        d1_q[i]  <= 33'(vin[i]) - 33'(eye_q[i]);
        dsq_q[i] <= f2_q.dm[i] * f2_q.dm[i];
        vsq_q[i] <= f2_q.vm[i] * f2_q.vm[i];
      end
      f2_q  <= f2_d;
      f3_q  <= f2_q;
      f4_q  <= f3_q;
      sqd_q <= 62'(dsq_q[0]) + 62'(dsq_q[1]) + 62'(dsq_q[2]);
      sqv_q <= 62'(vsq_q[0]) + 62'(vsq_q[1]) + 62'(vsq_q[2]);
    end
  end

  arvs_isqrt #(
    .K      (SQRT_K),
    .SIDE_W (FRONT_SIDE_W)
  ) u_isqrt (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (f4_vld_q),
    .xa_i   (sqd_q),
    .xb_i   (sqv_q),
    .side_i (f4_q),
    .vld_o  (sq_vld),
    .ra_o   (nd),
    .rb_o   (nv),
    .side_o (sq_side)
  );

  always_comb begin
    sq_fs       = front_side_t'(sq_side);
    dv_in.zero  = sq_fs.zero;
    dv_in.vzero = (nv == '0);
    dv_in.dneg  = sq_fs.dneg;
    dv_in.vneg  = sq_fs.vneg;
    for (int i = 0; i < 3; i++) begin
      num[i]     = DIV_NW'(sq_fs.dm[i]);
      num[i + 3] = DIV_NW'(sq_fs.vm[i]);
    end
  end

  arvs_div #(
    .QW     (DIV_QW),
    .NW     (DIV_NW),
    .SIDE_W (DIV_SIDE_W)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .vld_i   (sq_vld),
    .num_i   (num),
    .den_a_i (DIV_NW'(nd)),
    .den_b_i (DIV_NW'(nv)),
    .side_i  (dv_in),
    .vld_o   (dv_vld),
    .quo_o   (quo),
    .side_o  (dv_side)
  );

  always_comb begin
    dv_out = div_side_t'(dv_side);
    for (int i = 0; i < 3; i++) begin
      u[i] = dv_out.dneg[i] ? -32'(quo[i]) : 32'(quo[i]);
      if (dv_out.vzero) begin
        n[i] = '0;
      end else begin
        n[i] = dv_out.vneg[i] ? -32'(quo[i + 3]) : 32'(quo[i + 3]);
      end
    end
  end

  arvs_shade u_shade (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .vld_i   (dv_vld),
    .zero_i  (dv_out.zero),
    .u_i     (u),
    .n_i     (n),
    .sun_x_i (sun_q[0]),
    .sun_y_i (sun_q[1]),
    .sun_z_i (sun_q[2]),
    .fade_i  (fade_q),
    .vld_o   (pipe_vld),
    .pix_o   (pipe_pix)
  );

  // output register plus skid entry
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else if (out_vld_q && !m_axis_tready) begin
      if (en && pipe_vld) begin
        skid_vld_q <= 1'b1;
      end
    end else if (skid_vld_q) begin
      out_vld_q  <= 1'b1;
      skid_vld_q <= 1'b0;
    end else begin
      out_vld_q <= pipe_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_vld_q && !m_axis_tready) begin
      if (en && pipe_vld) begin
        skid_q <= pipe_pix;
      end
    end else if (skid_vld_q) begin
      out_q <= skid_q;
    end else begin
      out_q <= pipe_pix;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {out_q.alpha, out_q.blue, out_q.green, out_q.red};
  assign m_axis_tuser  = out_q.wr;

endmodule

`default_nettype wire

// ===== sv/arvs_chk.sv =====
// port-level checks for the atmosphere rim vertex shade unit
// bound to atmosphere_rim_vertex_shade_unit; no package dependency
`timescale 1ns / 1ps
`default_nettype none

module arvs_chk (
  input wire        clk_i,
  input wire        rst_ni,
  input wire        cfg_we_i,
  input wire [2:0]  cfg_idx_i,
  input wire [31:0] cfg_data_i,
  input wire        s_axis_tvalid,
  input wire        s_axis_tready,
  input wire [71:0] s_axis_tdata,
  input wire        m_axis_tvalid,
  input wire        m_axis_tready,
  input wire [63:0] m_axis_tdata,
  input wire        m_axis_tuser
);

  a_rst_idle: assert property (@(posedge clk_i) !rst_ni |-> !m_axis_tvalid)
    else $error("result valid during reset");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("stalled result changed");

  a_nowrite_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata == 64'd0)
    else $error("suppressed write carries colour");

  a_ready_low: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> $past(m_axis_tvalid && !m_axis_tready))
    else $error("input stalled without output back pressure");

endmodule

bind atmosphere_rim_vertex_shade_unit arvs_chk u_arvs_chk (.*);

`default_nettype wire

// ===== tb/tb_atmosphere_rim_vertex_shade_unit.sv =====
// testbench for the atmosphere rim vertex shade unit: directed and random vertices,
// colour prediction in a scoreboard class, random stalls on both stream sides
// depends on arvs_pkg and atmosphere_rim_vertex_shade_unit
`timescale 1ns / 1ps

module tb_atmosphere_rim_vertex_shade_unit import arvs_pkg::*; ();

  typedef struct {
    logic signed [31:0] ex, ey, ez;
    logic signed [15:0] sx, sy, sz;
    logic [15:0] fade;
  } shade_cfg_t;

  class shade_board;
    shade_cfg_t cfg;
    pix_t pending[$];
    int errors;

    function new();
      errors = 0;
      cfg.ex = 0; cfg.ey = 0; cfg.ez = 0;
      cfg.sx = SUN_X_RST; cfg.sy = 0; cfg.sz = 0;
      cfg.fade = 0;
    endfunction

    function longint unsigned mag(longint signed v);
      return v < 0 ? -v : v;
    endfunction

    function longint unsigned root(longint unsigned x);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > x) b >>= 2;
      while (b != 0) begin
        if (x >= r + b) begin
          x -= r + b;
          r = (r >> 1) + b;
        end else begin
          r >>= 1;
        end
        b >>= 2;
      end
      return r;
    endfunction

    function void normalize(input longint signed a[3], output longint signed u[3]);
      longint unsigned sq, n;
      sq = 0;
      for (int i = 0; i < 3; i++) sq += mag(a[i]) * mag(a[i]);
      n = root(sq);
      for (int i = 0; i < 3; i++)
        u[i] = (n != 0) ? (a[i] * (64'sd1 <<< 30)) / longint'(n) : 0;
    endfunction

    function longint signed shrink(longint signed v, int sh);
      longint unsigned m;
      m = mag(v) >> sh;
      return v < 0 ? -longint'(m) : longint'(m);
    endfunction

    function void note_vertex(logic [71:0] data);
      longint signed v[3], d[3], u[3], n[3], e[3], s[3], dot, sdot, sd, num;
      longint unsigned mx, c, g, thick, lit, dec, w, t, a;
      int sh;
      pix_t p;
      e = '{cfg.ex, cfg.ey, cfg.ez};
      s = '{cfg.sx, cfg.sy, cfg.sz};
      p = '0;
      for (int i = 0; i < 3; i++) begin
        v[i] = longint'($signed(data[24*i +: 24]));
        d[i] = v[i] - e[i];
      end
      if (d[0] == 0 && d[1] == 0 && d[2] == 0) begin
        pending.push_back(p);
        return;
      end
      mx = 0;
      for (int i = 0; i < 3; i++) if (mag(d[i]) > mx) mx = mag(d[i]);
      sh = 0;
      while ((mx >> sh) >= (64'd1 << 30)) sh++;
      for (int i = 0; i < 3; i++) d[i] = shrink(d[i], sh);
      normalize(d, u);
      normalize(v, n);
      dot = 0;
      sdot = 0;
      for (int i = 0; i < 3; i++) begin
        dot += u[i] * n[i];
        sdot += n[i] * s[i];
      end
      c = mag(dot) >> 44;
      if (c > 65536) c = 65536;
      g = 65536 - c;
      thick = (g * g * g) >> 32;
      sd = shrink(sdot, 28);
      num = sd + 16384;
      lit = 0;
      if (num > 0) begin
        lit = (longint'(num) * 20) / 9;
        if (lit > 65536) lit = 65536;
      end
      dec = (mag(sd) * 20) / 7;
      w = dec >= 65536 ? 0 : 65536 - dec;
      t = (w * 7) / 10;
      p.red   = 16'((longint'(SKY[0]) * (65536 - t) + longint'(WARM[0]) * t + 32768) >> 16);
      p.green = 16'((longint'(SKY[1]) * (65536 - t) + longint'(WARM[1]) * t + 32768) >> 16);
      p.blue  = 16'((longint'(SKY[2]) * (65536 - t) + longint'(WARM[2]) * t + 32768) >> 16);
      a = (thick * lit) >> 16;
      a = (a * cfg.fade) >> 15;
      a = (a * 19) / 20;
      if (a > 65536) a = 65536;
      p.alpha = 16'((a * 65535 + 32768) >> 16);
      p.wr = 1'b1;
      pending.push_back(p);
    endfunction

    function void check_pixel(logic [63:0] data, logic wr);
      pix_t x;
      if (pending.size() == 0) begin
        $error("unexpected transfer on master side");
        errors++;
        return;
      end
      x = pending.pop_front();
      if (data[15:0] !== x.red) begin
        $error("red exp %0d got %0d", x.red, data[15:0]); errors++;
      end
      if (data[31:16] !== x.green) begin
        $error("green exp %0d got %0d", x.green, data[31:16]); errors++;
      end
      if (data[47:32] !== x.blue) begin
        $error("blue exp %0d got %0d", x.blue, data[47:32]); errors++;
      end
      if (data[63:48] !== x.alpha) begin
        $error("alpha exp %0d got %0d", x.alpha, data[63:48]); errors++;
      end
      if (wr !== x.wr) begin
        $error("write_colour exp %0d got %0d", x.wr, wr); errors++;
      end
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        cfg_we_i = 1'b0;
  logic [2:0]  cfg_idx_i = '0;
  logic [31:0] cfg_data_i = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [71:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [63:0] m_axis_tdata;
  logic        m_axis_tuser;

  shade_board board = new();
  int send_idle, recv_idle;
  longint cycles = 0;

  atmosphere_rim_vertex_shade_unit dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (rst_ni && m_axis_tvalid && m_axis_tready) board.check_pixel(m_axis_tdata, m_axis_tuser);
    if (cycles > 400000) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // receiver stalls
  always @(negedge clk_i) m_axis_tready <= ($urandom_range(99) >= recv_idle);

  task automatic write_reg(logic [2:0] idx, logic [31:0] val);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      REG_EYE_X: board.cfg.ex = val;
      REG_EYE_Y: board.cfg.ey = val;
      REG_EYE_Z: board.cfg.ez = val;
      REG_SUN_X: board.cfg.sx = val[15:0];
      REG_SUN_Y: board.cfg.sy = val[15:0];
      REG_SUN_Z: board.cfg.sz = val[15:0];
      default:   board.cfg.fade = val[15:0];
    endcase
  endtask

  // valid stays high between back to back transfers
  task automatic send_vertex(logic [23:0] x, logic [23:0] y, logic [23:0] z);
    while ($urandom_range(99) < send_idle) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {z, y, x};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    board.note_vertex({z, y, x});
    @(negedge clk_i);
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (board.pending.size() != 0) @(negedge clk_i);
    repeat (5) @(negedge clk_i);
  endtask

  function automatic logic [23:0] rand_coord();
    case ($urandom_range(3))
      0: return 24'($urandom);
      1: return 24'($signed($urandom_range(2000)) - 1000);
      2: return $urandom_range(1) ? 24'h7FFFFF : 24'h800000;
      default: return 24'($signed($urandom_range(13000000)) - 6500000);
    endcase
  endfunction

  task automatic set_eye(logic [31:0] x, logic [31:0] y, logic [31:0] z);
    write_reg(REG_EYE_X, x);
    write_reg(REG_EYE_Y, y);
    write_reg(REG_EYE_Z, z);
  endtask

  task automatic set_sun(logic [15:0] x, logic [15:0] y, logic [15:0] z, logic [15:0] f);
    write_reg(REG_SUN_X, {16'd0, x});
    write_reg(REG_SUN_Y, {16'd0, y});
    write_reg(REG_SUN_Z, {16'd0, z});
    write_reg(REG_FADE, {16'd0, f});
  endtask

  task automatic random_phase(int count);
    logic [23:0] vx, vy, vz;
    for (int i = 0; i < count; i++) begin
      vx = rand_coord(); vy = rand_coord(); vz = rand_coord();
      if ($urandom_range(19) == 0) begin
        vx = board.cfg.ex[23:0]; vy = board.cfg.ey[23:0]; vz = board.cfg.ez[23:0];
      end
      send_vertex(vx, vy, vz);
    end
  endtask

  initial begin
    rst_ni <= 1'b0;
    send_idle = 6;
    recv_idle = 60;
    repeat (3) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    // defaults, eye at origin
    send_vertex(24'd0, 24'd0, 24'd0);
    send_vertex(24'd6400000, 24'd0, 24'd0);
    drain();
    set_sun(16'd0, 16'd16384, 16'd0, 16'd32768);
    set_eye(32'd6400000, 32'd0, 32'd0);
    send_vertex(24'd6400000, 24'd0, 24'd0);
    send_vertex(24'd6400001, 24'd0, 24'd0);
    send_vertex(24'd0, 24'd0, 24'd0);
    send_vertex(24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF);
    send_vertex(24'h800000, 24'h800000, 24'h800000);
    send_vertex(24'h800000, 24'h7FFFFF, 24'd1);
    drain();
    set_eye(32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF);
    set_sun(16'hC000, 16'h4000, 16'hC000, 16'hFFFF);
    send_vertex(24'h800000, 24'h7FFFFF, 24'h800000);
    send_vertex(24'd5, 24'hFFFFF0, 24'd100);
    send_vertex(24'd0, 24'd0, 24'd0);
    send_vertex(24'h123456, 24'hABCDEF, 24'h555555);
    drain();
    set_eye(32'hFFFFFC18, 32'd3000, 32'd0);
    set_sun(16'd3000, 16'hF000, 16'd8000, 16'd16384);
    send_vertex(24'hFFFC18, 24'd3000, 24'd0);
    send_vertex(24'hFFFC18, 24'd3000, 24'd1);
    send_vertex(24'd6371000, 24'd1000, 24'hFFFFFF);
    drain();

    for (int ph = 0; ph < 5; ph++) begin
      send_idle = (ph == 0) ? 6 : (ph == 1) ? 60 : 0;
      recv_idle = (ph == 0) ? 60 : (ph == 1) ? 6 : 0;
      set_eye($urandom_range(1) ? $urandom : 32'($signed($urandom_range(20000000)) - 10000000),
              $urandom_range(1) ? $urandom : 32'($signed($urandom_range(20000000)) - 10000000),
              $urandom_range(1) ? $urandom : 32'($signed($urandom_range(20000000)) - 10000000));
      set_sun(16'($signed($urandom_range(32768)) - 16384), 16'($urandom),
              16'($signed($urandom_range(32768)) - 16384),
              (ph == 4) ? 16'd32768 : 16'($urandom_range(32768)));
      random_phase(250);
      drain();
    end
    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end
endmodule
